FILE: hdl/mcn_pkg.sv
`default_nettype none
package mcn_pkg;

  localparam int MAX_VERTICES_DEF = 65536;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int DIV_W            = 64;
  localparam int SUM_W            = 48;

  // raw action codes on the input channel
  localparam logic [1:0] ACT_ACC  = 2'd0;
  localparam logic [1:0] ACT_FIN  = 2'd1;
  localparam logic [1:0] ACT_SCL  = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic RK_REPORT = 1'b0;
  localparam logic RK_VERTEX = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        scale_out;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [1:0] {OP_ACC, OP_FIN, OP_SCL, OP_NOP} op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } q_item_t;

  typedef enum logic [2:0] {BK_IDLE, BK_MUL, BK_RND, BK_DIV, BK_REPORT} bk_state_t;

  // saturate a sign and magnitude to signed 32 bits; bit 32 flags saturation
  function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end else begin
      if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(~mag[31:0] + 32'd1)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/mesh_centroid_and_normalize.sv
`default_nettype none
// Mesh bounding-box normalization in signed fixed point.
// Input channel in_valid/in_ready/in_data carries one action per transaction:
// accumulate a vertex, finish (report centroid and factor 2/max range), or
// scale a vertex by the held factor. Action code 3 is dropped on entry.
// Result channel out_valid/out_ready/out_data carries report and scaled
// vertex transactions in input order; accumulate produces none.
// A two-entry queue parts the front (accept, decode) from the back end.
// Accumulate: one vertex per cycle sustained while the back end is idle.
// Scale: vertex register, multiply, then round into the output register.
// Finish: the shared one-bit-per-cycle divider runs three divisions for
// the centroid and one for the factor, then the report state fills the
// output register (no factor division when every range is zero); an empty
// mesh writes its report straight into the output register, no division.
// The back end starts a result item only when the output register is empty,
// so a stalled receiver holds the result and backs up into the queue, then
// into in_ready. Synchronous reset clears sums, box, count and queue, and
// sets the held factor to 1.0.
module mesh_centroid_and_normalize #(
  parameter int MAX_VERTICES = mcn_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = mcn_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mcn_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mcn_pkg::out_item_t      out_data
);
  logic             q_valid, q_pop;
  mcn_pkg::q_item_t q_item;

  mcn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mcn_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

FILE: hdl/mcn_div.sv
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle
module mcn_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [mcn_pkg::DIV_W-1:0] dvd,
  input  wire logic [31:0]               dvs,
  output logic                           done,
  output logic [mcn_pkg::DIV_W-1:0]      quo
);
  localparam int CW = $clog2(mcn_pkg::DIV_W);

  logic [31:0]               rem_r, rem_nxt;
  logic [mcn_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [31:0]               dvs_r;
  logic [CW-1:0]             cnt_r;
  logic                      busy_r, done_r;
  logic [32:0]               trial;

  // shift in one dividend bit and try the subtract
  always_comb begin
    trial   = {rem_r, quo_r[mcn_pkg::DIV_W-1]};
    rem_nxt = rem_r;
    quo_nxt = {quo_r[mcn_pkg::DIV_W-2:0], 1'b0};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt    = 32'(trial - {1'b0, dvs_r});
      quo_nxt[0] = 1'b1;
    end else begin
      rem_nxt = trial[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dvd;
        dvs_r  <= dvs;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(mcn_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

FILE: hdl/mcn_front.sv
`default_nettype none
// Accept transactions, decode the action and queue them for the back end
module mcn_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mcn_pkg::in_item_t in_data,
  output logic                   q_valid,
  output mcn_pkg::q_item_t       q_item,
  input  wire logic              q_pop
);
  mcn_pkg::q_item_t slot_r [2];
  logic [1:0]       cnt_r;
  logic             wp_r, rp_r;
  logic             push;
  mcn_pkg::q_item_t dec;

  // classify the action; unused codes are dropped here
  always_comb begin
    dec.x = in_data.in_x;
    dec.y = in_data.in_y;
    dec.z = in_data.in_z;
    unique case (in_data.action)
      mcn_pkg::ACT_ACC: dec.op = mcn_pkg::OP_ACC;
      mcn_pkg::ACT_FIN: dec.op = mcn_pkg::OP_FIN;
      mcn_pkg::ACT_SCL: dec.op = mcn_pkg::OP_SCL;
      default:          dec.op = mcn_pkg::OP_NOP;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && (dec.op != mcn_pkg::OP_NOP);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/mcn_back.sv
`default_nettype none
// Execute queued items: accumulate, finish with shared divider, scale
module mcn_back #(
  parameter int MAX_VERTICES = mcn_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = mcn_pkg::FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire mcn_pkg::q_item_t q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mcn_pkg::out_item_t    out_data
);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int SW    = mcn_pkg::SUM_W;
  localparam logic [63:0] RND = (64'd1 << FRAC_BITS) - 64'd1;

  mcn_pkg::bk_state_t st_r, st_nxt;

  logic signed [SW-1:0] sum_r [3];
  logic signed [31:0]   mn_r [3];
  logic signed [31:0]   mx_r [3];
  logic [CNT_W-1:0]     cnt_r;
  logic [31:0]          held_r;

  logic signed [SW-1:0] fsum_r [3];
  logic [CNT_W-1:0]     fcnt_r;
  logic [31:0]          range_r;
  logic [31:0]          cen_r [3];
  logic [31:0]          scale_r;
  logic                 sat_r;
  logic [1:0]           idx_r;

  logic [31:0]          v_r [3];
  logic [63:0]          prod_r [3];

  logic                 out_valid_r;
  mcn_pkg::out_item_t   out_r;

  logic                 div_start, div_done;
  logic [63:0]          div_dvd, div_quo;
  logic [31:0]          div_dvs;
  logic [31:0]          rng [3];
  logic [31:0]          rng_max;
  logic [SW-1:0]        mag_sel;
  logic [32:0]          cen_sat;

  // largest axis range of the current box
  always_comb begin
    for (int i = 0; i < 3; i++) rng[i] = 32'(33'(mx_r[i]) - 33'(mn_r[i]));
    rng_max = rng[0];
    if (rng[1] > rng_max) rng_max = rng[1];
    if (rng[2] > rng_max) rng_max = rng[2];
  end

  assign cen_sat = mcn_pkg::sat_mag(fsum_r[idx_r][SW-1], div_quo);

  // next state, queue pop and divider launch
  always_comb begin
    st_nxt    = st_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    mag_sel   = sum_r[0][SW-1] ? SW'(-sum_r[0]) : SW'(sum_r[0]);
    div_dvd   = 64'(mag_sel);
    div_dvs   = 32'(cnt_r);
    unique case (st_r)
      mcn_pkg::BK_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            mcn_pkg::OP_FIN: begin
              if (!out_valid_r) begin
                q_pop = 1'b1;
                if (cnt_r != '0) begin
                  div_start = 1'b1;
                  st_nxt    = mcn_pkg::BK_DIV;
                end
              end
            end
            mcn_pkg::OP_SCL: begin
              if (!out_valid_r) begin
                q_pop  = 1'b1;
                st_nxt = mcn_pkg::BK_MUL;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      mcn_pkg::BK_MUL: st_nxt = mcn_pkg::BK_RND;
      mcn_pkg::BK_RND: st_nxt = mcn_pkg::BK_IDLE;
      mcn_pkg::BK_DIV: begin
        if (div_done) begin
          if (idx_r == 2'd2 && range_r == '0) begin
            st_nxt = mcn_pkg::BK_REPORT;
          end else if (idx_r == 2'd3) begin
            st_nxt = mcn_pkg::BK_REPORT;
          end else begin
            div_start = 1'b1;
            if (idx_r == 2'd2) begin
              div_dvd = 64'd1 << (2 * FRAC_BITS + 1);
              div_dvs = range_r;
            end else begin
              mag_sel = fsum_r[idx_r + 2'd1][SW-1] ? SW'(-fsum_r[idx_r + 2'd1])
                                                  : SW'(fsum_r[idx_r + 2'd1]);
              div_dvd = 64'(mag_sel);
              div_dvs = 32'(fcnt_r);
            end
          end
        end
      end
      mcn_pkg::BK_REPORT: st_nxt = mcn_pkg::BK_IDLE;
      default: st_nxt = mcn_pkg::BK_IDLE;
    endcase
  end

  mcn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= mcn_pkg::BK_IDLE;
    else st_r <= st_nxt;
  end

  // accumulators, held factor and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
        mn_r[i]  <= '0;
        mx_r[i]  <= '0;
      end
      cnt_r       <= '0;
      held_r      <= 32'(64'd1 << FRAC_BITS);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (q_pop && q_item.op == mcn_pkg::OP_ACC && cnt_r < CNT_W'(MAX_VERTICES)) begin
        sum_r[0] <= sum_r[0] + SW'(signed'(q_item.x));
        sum_r[1] <= sum_r[1] + SW'(signed'(q_item.y));
        sum_r[2] <= sum_r[2] + SW'(signed'(q_item.z));
        if (signed'(q_item.x) < mn_r[0]) mn_r[0] <= q_item.x;
        if (signed'(q_item.y) < mn_r[1]) mn_r[1] <= q_item.y;
        if (signed'(q_item.z) < mn_r[2]) mn_r[2] <= q_item.z;
        if (signed'(q_item.x) > mx_r[0]) mx_r[0] <= q_item.x;
        if (signed'(q_item.y) > mx_r[1]) mx_r[1] <= q_item.y;
        if (signed'(q_item.z) > mx_r[2]) mx_r[2] <= q_item.z;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (q_pop && q_item.op == mcn_pkg::OP_FIN) begin
        for (int i = 0; i < 3; i++) begin
          sum_r[i] <= '0;
          mn_r[i]  <= '0;
          mx_r[i]  <= '0;
        end
        cnt_r <= '0;
        if (cnt_r == '0) out_valid_r <= 1'b1;
      end
      if (st_r == mcn_pkg::BK_DIV && div_done && idx_r == 2'd3) begin
        held_r <= (div_quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_quo[31:0];
      end
      if (st_r == mcn_pkg::BK_RND || st_r == mcn_pkg::BK_REPORT) out_valid_r <= 1'b1;
    end
  end

  // finish and scale datapath, output payload
  always_ff @(posedge clk) begin
    logic [63:0] m;
    logic [32:0] s [3];
    if (q_pop && q_item.op == mcn_pkg::OP_FIN) begin
      for (int i = 0; i < 3; i++) fsum_r[i] <= sum_r[i];
      fcnt_r  <= cnt_r;
      range_r <= rng_max;
      sat_r   <= 1'b0;
      idx_r   <= 2'd0;
      scale_r <= '0;
      if (cnt_r == '0) begin
        out_r <= '{result_kind: mcn_pkg::RK_REPORT, out_x: '0, out_y: '0, out_z: '0,
                   scale_out: '0, status: mcn_pkg::ST_EMPTY};
      end
    end
    if (q_pop && q_item.op == mcn_pkg::OP_SCL) begin
      v_r[0] <= q_item.x;
      v_r[1] <= q_item.y;
      v_r[2] <= q_item.z;
    end
    if (st_r == mcn_pkg::BK_DIV && div_done) begin
      idx_r <= idx_r + 2'd1;
      if (idx_r == 2'd3) begin
        if (div_quo > 64'hFFFF_FFFF) begin
          scale_r <= 32'hFFFF_FFFF;
          sat_r   <= 1'b1;
        end else begin
          scale_r <= div_quo[31:0];
        end
      end else begin
        cen_r[idx_r] <= cen_sat[31:0];
        if (cen_sat[32]) sat_r <= 1'b1;
      end
    end
    if (st_r == mcn_pkg::BK_MUL) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= 64'(v_r[i][31] ? 32'(-v_r[i]) : v_r[i]) * 64'(held_r);
      end
    end
    if (st_r == mcn_pkg::BK_RND) begin
      for (int i = 0; i < 3; i++) begin
        m    = v_r[i][31] ? ((prod_r[i] + RND) >> FRAC_BITS) : (prod_r[i] >> FRAC_BITS);
        s[i] = mcn_pkg::sat_mag(v_r[i][31], m);
      end
      out_r.result_kind <= mcn_pkg::RK_VERTEX;
      out_r.out_x       <= s[0][31:0];
      out_r.out_y       <= s[1][31:0];
      out_r.out_z       <= s[2][31:0];
      out_r.scale_out   <= held_r;
      out_r.status      <= (s[0][32] || s[1][32] || s[2][32]) ? mcn_pkg::ST_SAT
                                                             : mcn_pkg::ST_OK;
    end
    if (st_r == mcn_pkg::BK_REPORT) begin
      out_r.result_kind <= mcn_pkg::RK_REPORT;
      out_r.out_x       <= cen_r[0];
      out_r.out_y       <= cen_r[1];
      out_r.out_z       <= cen_r[2];
      out_r.scale_out   <= scale_r;
      if (range_r == '0) out_r.status <= mcn_pkg::ST_ZERO;
      else out_r.status <= sat_r ? mcn_pkg::ST_SAT : mcn_pkg::ST_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

FILE: hdl/mcn_checker.sv
`default_nettype none
module mcn_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire mcn_pkg::out_item_t out_data
);
  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // scaled vertices report only ok or saturated
  a_vkind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == mcn_pkg::RK_VERTEX |->
      out_data.status == mcn_pkg::ST_OK || out_data.status == mcn_pkg::ST_SAT)
    else $error("bad status on scaled vertex");

  // empty mesh reports zeros
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == mcn_pkg::RK_REPORT &&
    out_data.status == mcn_pkg::ST_EMPTY |->
      out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0 &&
      out_data.scale_out == '0)
    else $error("empty report not zero");

  // zero range reports no factor
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == mcn_pkg::RK_REPORT &&
    out_data.status == mcn_pkg::ST_ZERO |-> out_data.scale_out == '0)
    else $error("zero range with factor");
endmodule

bind mesh_centroid_and_normalize mcn_checker u_mcn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
